### src/wiper_sweep_sequencer_top_assert.svh
// assertion macros shared by the wiper sweep sequencer checker
`ifndef WIPER_SWEEP_SEQUENCER_TOP_ASSERT_SVH
`define WIPER_SWEEP_SEQUENCER_TOP_ASSERT_SVH

// property checked only while reset is low
`define WSS_ASSERT_RUN(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked at every edge, reset included
`define WSS_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/wss_pkg.sv
// types, constants and register codes for the wiper sweep sequencer
`timescale 1ns / 1ps
`default_nettype none

package wss_pkg;

   localparam int TICK_MS_DEFAULT    = 10;
   localparam int REST_DUTY_DEFAULT  = 800;
   localparam int SWEEP_DUTY_DEFAULT = 3300;

   localparam int SAMPLE_W  = 12;
   localparam int DUTY_W    = 12;
   localparam int MS_W      = 14;
   localparam int ELAPSED_W = 16;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 14;

   localparam logic [SAMPLE_W-1:0] THRESH_INT_RESET  = 12'd500;
   localparam logic [SAMPLE_W-1:0] THRESH_LOW_RESET  = 12'd2000;
   localparam logic [SAMPLE_W-1:0] THRESH_HIGH_RESET = 12'd3500;
   localparam logic [MS_W-1:0]     SWEEP_INT_RESET   = 14'd500;
   localparam logic [MS_W-1:0]     SWEEP_LOW_RESET   = 14'd800;
   localparam logic [MS_W-1:0]     SWEEP_HIGH_RESET  = 14'd300;
   localparam logic [MS_W-1:0]     PAUSE_RESET       = 14'd3000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_THRESH_INT  = 3'd0,
      CSR_THRESH_LOW  = 3'd1,
      CSR_THRESH_HIGH = 3'd2,
      CSR_SWEEP_INT   = 3'd3,
      CSR_SWEEP_LOW   = 3'd4,
      CSR_SWEEP_HIGH  = 3'd5,
      CSR_PAUSE       = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      SPEED_OFF   = 2'd0,
      SPEED_PULSE = 2'd1,
      SPEED_SLOW  = 2'd2,
      SPEED_FAST  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      PHASE_IDLE = 2'd0,
      PHASE_UP   = 2'd1,
      PHASE_DOWN = 2'd2
   } phase_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] knob_sample;
      logic                use_remote;
      logic [1:0]          remote_mode;
   } req_type;

   typedef struct packed {
      logic [DUTY_W-1:0] servo_duty;
      logic              duty_written;
      logic [1:0]        wiper_mode;
      logic [1:0]        wiper_phase;
   } rsp_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] thresh_intermittent;
      logic [SAMPLE_W-1:0] thresh_low;
      logic [SAMPLE_W-1:0] thresh_high;
      logic [MS_W-1:0]     sweep_ms_intermittent;
      logic [MS_W-1:0]     sweep_ms_low;
      logic [MS_W-1:0]     sweep_ms_high;
      logic [MS_W-1:0]     pause_ms;
   } cfg_type;

   typedef struct packed {
      phase_type            phase;
      logic [ELAPSED_W-1:0] elapsed_ms;
      logic [DUTY_W-1:0]    held_duty;
   } state_type;

endpackage

`default_nettype wire

### src/wss_chan_if.sv
// valid/ready channel carrying one payload beat
`timescale 1ns / 1ps
`default_nettype none

interface wss_chan_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

### src/wss_core.sv
// per-tick mode choice and phase sequencing, purely combinational
`timescale 1ns / 1ps
`default_nettype none

module wss_core #(
   parameter int TICK_MS    = wss_pkg::TICK_MS_DEFAULT,
   parameter int REST_DUTY  = wss_pkg::REST_DUTY_DEFAULT,
   parameter int SWEEP_DUTY = wss_pkg::SWEEP_DUTY_DEFAULT
) (
   input  wss_pkg::req_type   req,
   input  wss_pkg::cfg_type   cfg,
   input  wss_pkg::state_type cur,
   output wss_pkg::state_type nxt,
   output wss_pkg::rsp_type   rsp
);

   localparam logic [wss_pkg::DUTY_W-1:0] REST_CODE  = wss_pkg::DUTY_W'(REST_DUTY);
   localparam logic [wss_pkg::DUTY_W-1:0] SWEEP_CODE = wss_pkg::DUTY_W'(SWEEP_DUTY);
   localparam logic [wss_pkg::ELAPSED_W:0] TICK_CODE = (wss_pkg::ELAPSED_W+1)'(TICK_MS);
   localparam logic [wss_pkg::ELAPSED_W-1:0] ELAPSED_MAX = '1;

   wss_pkg::mode_type                mode;
   logic [wss_pkg::MS_W-1:0]         dur;
   logic [wss_pkg::MS_W:0]           target;
   logic                             start;
   wss_pkg::phase_type               phase_eff;
   logic [wss_pkg::ELAPSED_W-1:0]    elapsed_base;
   logic [wss_pkg::ELAPSED_W:0]      elapsed_sum;
   logic [wss_pkg::ELAPSED_W-1:0]    elapsed_adv;
   logic                             up_done;
   logic                             down_done;

   // shared decode: mode cascade, phase time and advanced timer
   always_comb begin
      if (req.use_remote) begin
         mode = wss_pkg::mode_type'(req.remote_mode);
      end else if (req.knob_sample < cfg.thresh_intermittent) begin
         mode = wss_pkg::SPEED_OFF;
      end else if (req.knob_sample < cfg.thresh_low) begin
         mode = wss_pkg::SPEED_PULSE;
      end else if (req.knob_sample < cfg.thresh_high) begin
         mode = wss_pkg::SPEED_SLOW;
      end else begin
         mode = wss_pkg::SPEED_FAST;
      end

      case (mode)
         wss_pkg::SPEED_PULSE: dur = cfg.sweep_ms_intermittent;
         wss_pkg::SPEED_SLOW:  dur = cfg.sweep_ms_low;
         default:              dur = cfg.sweep_ms_high;
      endcase

      if (mode == wss_pkg::SPEED_PULSE) begin
         target = {1'b0, dur} + {1'b0, cfg.pause_ms};
      end else begin
         target = {1'b0, dur};
      end

      start        = (cur.phase == wss_pkg::PHASE_IDLE);
      phase_eff    = start ? wss_pkg::PHASE_UP : cur.phase;
      elapsed_base = start ? '0 : cur.elapsed_ms;
      elapsed_sum  = {1'b0, elapsed_base} + TICK_CODE;
      // timer saturates rather than wrapping
      elapsed_adv  = elapsed_sum[wss_pkg::ELAPSED_W] ? ELAPSED_MAX
                                                     : elapsed_sum[wss_pkg::ELAPSED_W-1:0];
      up_done   = (elapsed_adv >= wss_pkg::ELAPSED_W'(dur));
      down_done = (elapsed_adv >= wss_pkg::ELAPSED_W'(target));
   end

   // next phase and timer
   always_comb begin
      nxt.held_duty = rsp.servo_duty;
      if (mode == wss_pkg::SPEED_OFF) begin
         nxt.phase      = wss_pkg::PHASE_IDLE;
         nxt.elapsed_ms = '0;
      end else begin
         case (phase_eff)
            wss_pkg::PHASE_UP: begin
               nxt.phase      = up_done ? wss_pkg::PHASE_DOWN : wss_pkg::PHASE_UP;
               nxt.elapsed_ms = up_done ? '0 : elapsed_adv;
            end
            wss_pkg::PHASE_DOWN: begin
               nxt.phase      = down_done ? wss_pkg::PHASE_IDLE : wss_pkg::PHASE_DOWN;
               nxt.elapsed_ms = down_done ? '0 : elapsed_adv;
            end
            default: begin
               // stray phase code: back to idle, timer keeps its advanced value
               nxt.phase      = wss_pkg::PHASE_IDLE;
               nxt.elapsed_ms = elapsed_adv;
            end
         endcase
      end
   end

   // result beat
   always_comb begin
      rsp.wiper_mode  = mode;
      rsp.wiper_phase = nxt.phase;
      if (mode == wss_pkg::SPEED_OFF) begin
         rsp.servo_duty   = REST_CODE;
         rsp.duty_written = 1'b1;
      end else if (phase_eff == wss_pkg::PHASE_UP && up_done) begin
         rsp.servo_duty   = REST_CODE;
         rsp.duty_written = 1'b1;
      end else if (start) begin
         rsp.servo_duty   = SWEEP_CODE;
         rsp.duty_written = 1'b1;
      end else begin
         rsp.servo_duty   = cur.held_duty;
         rsp.duty_written = 1'b0;
      end
   end

endmodule

`default_nettype wire

### src/wss_out_queue.sv
// two-entry result queue so a stalled beat does not block the input side
`timescale 1ns / 1ps
`default_nettype none

module wss_out_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  wss_pkg::rsp_type in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output wss_pkg::rsp_type out_data
);

   wss_pkg::rsp_type entry_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             push, pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      case ({push, pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

`default_nettype wire

### src/wiper_sweep_sequencer_top.sv
// wiper sweep sequencer: registers, sequencer state and result queue
//
//   port       dir   beat contents
//   req_chan   in    knob_sample, use_remote, remote_mode (one timer tick)
//   rsp_chan   out   servo_duty, duty_written, wiper_mode, wiper_phase
//   csr_*      in    write enable, register index 0..6, 14-bit data
//
// one tick per clock while the result queue has room; each accepted beat
// updates the state and enters its result in the result queue at that edge.
// req_chan.ready drops only when both result queue entries are full.
// synchronous reset initialises state, registers and queue; no clearing pass.
// csr writes take effect at the next edge.
`timescale 1ns / 1ps
`default_nettype none

module wiper_sweep_sequencer_top #(
   parameter int TICK_MS    = wss_pkg::TICK_MS_DEFAULT,
   parameter int REST_DUTY  = wss_pkg::REST_DUTY_DEFAULT,
   parameter int SWEEP_DUTY = wss_pkg::SWEEP_DUTY_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   wss_chan_if.sink                        req_chan,
   wss_chan_if.source                      rsp_chan,
   input  logic                            csr_write_en,
   input  logic [wss_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [wss_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   wss_pkg::cfg_type   cfg_ff, cfg_in;
   wss_pkg::state_type state_ff, state_nxt;
   wss_pkg::rsp_type   core_rsp;
   wss_pkg::req_type   req_beat;
   logic               req_ready;
   logic               req_fire;

   assign req_beat       = req_chan.payload;
   assign req_chan.ready = req_ready;
   assign req_fire       = req_chan.valid && req_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (wss_pkg::csr_index_type'(csr_index))
            wss_pkg::CSR_THRESH_INT:  cfg_in.thresh_intermittent   = csr_wdata[11:0];
            wss_pkg::CSR_THRESH_LOW:  cfg_in.thresh_low            = csr_wdata[11:0];
            wss_pkg::CSR_THRESH_HIGH: cfg_in.thresh_high           = csr_wdata[11:0];
            wss_pkg::CSR_SWEEP_INT:   cfg_in.sweep_ms_intermittent = csr_wdata;
            wss_pkg::CSR_SWEEP_LOW:   cfg_in.sweep_ms_low          = csr_wdata;
            wss_pkg::CSR_SWEEP_HIGH:  cfg_in.sweep_ms_high         = csr_wdata;
            wss_pkg::CSR_PAUSE:       cfg_in.pause_ms              = csr_wdata;
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.thresh_intermittent   <= wss_pkg::THRESH_INT_RESET;
         cfg_ff.thresh_low            <= wss_pkg::THRESH_LOW_RESET;
         cfg_ff.thresh_high           <= wss_pkg::THRESH_HIGH_RESET;
         cfg_ff.sweep_ms_intermittent <= wss_pkg::SWEEP_INT_RESET;
         cfg_ff.sweep_ms_low          <= wss_pkg::SWEEP_LOW_RESET;
         cfg_ff.sweep_ms_high         <= wss_pkg::SWEEP_HIGH_RESET;
         cfg_ff.pause_ms              <= wss_pkg::PAUSE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   wss_core #(
      .TICK_MS    (TICK_MS),
      .REST_DUTY  (REST_DUTY),
      .SWEEP_DUTY (SWEEP_DUTY)
   ) u_core (
      .req (req_beat),
      .cfg (cfg_ff),
      .cur (state_ff),
      .nxt (state_nxt),
      .rsp (core_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase      <= wss_pkg::PHASE_IDLE;
         state_ff.elapsed_ms <= '0;
         state_ff.held_duty  <= wss_pkg::DUTY_W'(REST_DUTY);
      end else if (req_fire) begin
         state_ff <= state_nxt;
      end
   end

   wss_out_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_ready  (req_ready),
      .in_data   (core_rsp),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_data  (rsp_chan.payload)
   );

endmodule

`default_nettype wire

### src/wss_checker.sv
// port-level checks on the wiper sweep sequencer, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "wiper_sweep_sequencer_top_assert.svh"

module wss_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input wss_pkg::rsp_type rsp_payload
);

   // a stalled result beat stays offered and unchanged
   `WSS_ASSERT_RUN(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload), "stalled result beat dropped or changed")

   // reset empties the result side
   `WSS_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "result beat offered right after reset")

   // with nothing waiting on the result side the input is never held off
   `WSS_ASSERT_RUN(a_idle_ready, clock, reset, !rsp_valid |-> req_ready, "input stalled while result side is empty")

   // an accepted tick always leaves a beat to take on the next cycle
   `WSS_ASSERT_RUN(a_tick_result, clock, reset, req_valid && req_ready |=> rsp_valid, "accepted tick left no result beat")

endmodule

bind wiper_sweep_sequencer_top wss_checker u_wss_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_payload (rsp_chan.payload)
);

`default_nettype wire

### bench/tb_wiper_sweep_sequencer_top.sv
// self-checking bench for the wiper sweep sequencer: tick stream, mode and phase checks
`timescale 1ns / 1ps

module tb_wiper_sweep_sequencer_top;
   import wss_pkg::*;

   localparam int TICK_STEP_MS = TICK_MS_DEFAULT;
   localparam int CYCLE_LIMIT  = 200000;

   logic clock;
   logic reset;
   logic                  csr_write_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   wss_chan_if #(.payload_type(req_type)) req_chan ();
   wss_chan_if #(.payload_type(rsp_type)) rsp_chan ();

   wiper_sweep_sequencer_top dut (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_chan),
      .rsp_chan     (rsp_chan),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   req_type ticks_to_send [$];
   rsp_type wiper_status_due [$];

   // bench copy of the registers and the sequencer state
   cfg_type           wiper_cfg = '{THRESH_INT_RESET, THRESH_LOW_RESET, THRESH_HIGH_RESET,
                                    SWEEP_INT_RESET, SWEEP_LOW_RESET, SWEEP_HIGH_RESET,
                                    PAUSE_RESET};
   phase_type         seq_phase   = PHASE_IDLE;
   int                seq_elapsed = 0;
   logic [DUTY_W-1:0] seq_duty    = DUTY_W'(REST_DUTY_DEFAULT);

   int fail_count  = 0;
   int cycle_count = 0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   function automatic rsp_type next_wiper_status(input req_type tick);
      mode_type m;
      logic     wrote;
      int       span;
      int       limit;
      rsp_type  r;
      wrote = 1'b0;
      // threshold cascade: the first test that holds decides, whatever the ordering
      if (tick.use_remote)
         m = mode_type'(tick.remote_mode);
      else if (tick.knob_sample < wiper_cfg.thresh_intermittent)
         m = SPEED_OFF;
      else if (tick.knob_sample < wiper_cfg.thresh_low)
         m = SPEED_PULSE;
      else if (tick.knob_sample < wiper_cfg.thresh_high)
         m = SPEED_SLOW;
      else
         m = SPEED_FAST;
      if (m == SPEED_OFF) begin
         seq_duty    = DUTY_W'(REST_DUTY_DEFAULT);
         wrote       = 1'b1;
         seq_phase   = PHASE_IDLE;
         seq_elapsed = 0;
      end else begin
         case (m)
            SPEED_PULSE: span = wiper_cfg.sweep_ms_intermittent;
            SPEED_SLOW:  span = wiper_cfg.sweep_ms_low;
            default:     span = wiper_cfg.sweep_ms_high;
         endcase
         if (seq_phase == PHASE_IDLE) begin
            seq_phase   = PHASE_UP;
            seq_elapsed = 0;
            seq_duty    = DUTY_W'(SWEEP_DUTY_DEFAULT);
            wrote       = 1'b1;
         end
         seq_elapsed = seq_elapsed + TICK_STEP_MS;
         if (seq_elapsed > 65535)
            seq_elapsed = 65535;
         if (seq_phase == PHASE_UP) begin
            if (seq_elapsed >= span) begin
               seq_phase   = PHASE_DOWN;
               seq_elapsed = 0;
               seq_duty    = DUTY_W'(REST_DUTY_DEFAULT);
               wrote       = 1'b1;
            end
         end else if (seq_phase == PHASE_DOWN) begin
            limit = (m == SPEED_PULSE) ? span + int'(wiper_cfg.pause_ms) : span;
            if (seq_elapsed >= limit) begin
               seq_phase   = PHASE_IDLE;
               seq_elapsed = 0;
            end
         end else begin
            seq_phase = PHASE_IDLE;
         end
      end
      r.servo_duty   = seq_duty;
      r.duty_written = wrote;
      r.wiper_mode   = m;
      r.wiper_phase  = seq_phase;
      return r;
   endfunction

   // sender: bursts of random length with random gaps
   int burst_left = 0;
   int gap_left   = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready)
            wiper_status_due.push_back(next_wiper_status(req_chan.payload));
         if (!req_chan.valid || req_chan.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_chan.valid <= 1'b0;
            end else if (ticks_to_send.size() > 0) begin
               req_chan.valid   <= 1'b1;
               req_chan.payload <= ticks_to_send.pop_front();
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 40);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               end else begin
                  burst_left--;
               end
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // receiver: changing stall styles plus an occasional long hold-off
   int hold_left    = 0;
   int next_hold_at = 300;
   int beats_taken  = 0;
   int style_left   = 0;
   int stall_style  = 0;
   int pattern_ctr  = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready)
            beats_taken++;
         pattern_ctr++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else if (beats_taken >= next_hold_at) begin
            hold_left    = $urandom_range(150, 300);
            next_hold_at = next_hold_at + 400;
            rsp_chan.ready <= 1'b0;
         end else begin
            if (style_left == 0) begin
               stall_style = $urandom_range(0, 2);
               style_left  = $urandom_range(20, 80);
            end else begin
               style_left--;
            end
            case (stall_style)
               0:       rsp_chan.ready <= 1'b1;
               1:       rsp_chan.ready <= ($urandom_range(0, 3) != 0);
               default: rsp_chan.ready <= (pattern_ctr % 5 < 3);
            endcase
         end
      end
   end

   task automatic compare_field(input string name, input logic [11:0] want,
                                input logic [11:0] got);
      if (got !== want) begin
         $error("%s expected %0d got %0d", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (wiper_status_due.size() == 0) begin
            $error("result beat with nothing expected: duty %0d mode %0d phase %0d",
                   rsp_chan.payload.servo_duty, rsp_chan.payload.wiper_mode,
                   rsp_chan.payload.wiper_phase);
            fail_count++;
         end else begin
            want = wiper_status_due.pop_front();
            compare_field("servo_duty", want.servo_duty, rsp_chan.payload.servo_duty);
            compare_field("duty_written", want.duty_written, rsp_chan.payload.duty_written);
            compare_field("wiper_mode", want.wiper_mode, rsp_chan.payload.wiper_mode);
            compare_field("wiper_phase", want.wiper_phase, rsp_chan.payload.wiper_phase);
         end
      end
   end

   function automatic req_type mk_tick(input logic [SAMPLE_W-1:0] sample,
                                       input logic remote, input mode_type m);
      req_type t;
      t.knob_sample = sample;
      t.use_remote  = remote;
      t.remote_mode = m;
      return t;
   endfunction

   function automatic cfg_type make_cfg(input int t_int, input int t_low, input int t_high,
                                        input int s_int, input int s_low, input int s_high,
                                        input int pause);
      cfg_type c;
      c.thresh_intermittent   = SAMPLE_W'(t_int);
      c.thresh_low            = SAMPLE_W'(t_low);
      c.thresh_high           = SAMPLE_W'(t_high);
      c.sweep_ms_intermittent = MS_W'(s_int);
      c.sweep_ms_low          = MS_W'(s_low);
      c.sweep_ms_high         = MS_W'(s_high);
      c.pause_ms              = MS_W'(pause);
      return c;
   endfunction

   function automatic cfg_type random_cfg(input int ms_max, input bit ascending);
      int a;
      int b;
      int c;
      int tmp;
      a = $urandom_range(0, 4095);
      b = $urandom_range(0, 4095);
      c = $urandom_range(0, 4095);
      if (ascending) begin
         if (a > b) begin tmp = a; a = b; b = tmp; end
         if (b > c) begin tmp = b; b = c; c = tmp; end
         if (a > b) begin tmp = a; a = b; b = tmp; end
      end
      return make_cfg(a, b, c, $urandom_range(0, ms_max), $urandom_range(0, ms_max),
                      $urandom_range(0, ms_max), $urandom_range(0, 2 * ms_max));
   endfunction

   task automatic csr_write(input csr_index_type idx, input logic [CSR_DATA_W-1:0] val);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= val;
      @(posedge clock);
   endtask

   // called at a clock edge with the block idle
   task automatic write_settings(input cfg_type c);
      csr_write(CSR_THRESH_INT, c.thresh_intermittent);
      csr_write(CSR_THRESH_LOW, c.thresh_low);
      csr_write(CSR_THRESH_HIGH, c.thresh_high);
      csr_write(CSR_SWEEP_INT, c.sweep_ms_intermittent);
      csr_write(CSR_SWEEP_LOW, c.sweep_ms_low);
      csr_write(CSR_SWEEP_HIGH, c.sweep_ms_high);
      csr_write(CSR_PAUSE, c.pause_ms);
      csr_write_en <= 1'b0;
      wiper_cfg = c;
   endtask

   task automatic wait_drained();
      do
         @(posedge clock);
      while (ticks_to_send.size() != 0 || req_chan.valid || wiper_status_due.size() != 0);
   endtask

   // mostly runs with a steady mode so sweeps run to completion, some pure noise
   task automatic queue_random_ticks(input int count);
      int                  left;
      int                  run;
      int                  kind;
      logic [SAMPLE_W-1:0] base;
      mode_type            held_mode;
      req_type             t;
      left = count;
      while (left > 0) begin
         run = $urandom_range(1, 60);
         if (run > left)
            run = left;
         kind      = $urandom_range(0, 9);
         base      = $urandom_range(0, 4095);
         held_mode = mode_type'($urandom_range(0, 3));
         for (int i = 0; i < run; i++) begin
            t.knob_sample = $urandom_range(0, 4095);
            t.remote_mode = $urandom_range(0, 3);
            t.use_remote  = $urandom_range(0, 1);
            if (kind < 4) begin
               t.use_remote  = 1'b1;
               t.remote_mode = held_mode;
            end else if (kind < 8) begin
               t.use_remote  = 1'b0;
               t.knob_sample = base ^ SAMPLE_W'($urandom_range(0, 3));
            end
            ticks_to_send.push_back(t);
         end
         left -= run;
      end
   endtask

   initial begin
      reset            = 1'b1;
      req_chan.valid   = 1'b0;
      req_chan.payload = '0;
      rsp_chan.ready   = 1'b0;
      csr_write_en     = 1'b0;
      csr_index        = CSR_THRESH_INT;
      csr_wdata        = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset thresholds: band edges on the knob, then every remote request
      ticks_to_send.push_back(mk_tick(12'd0, 1'b0, SPEED_FAST));
      ticks_to_send.push_back(mk_tick(12'd499, 1'b0, SPEED_OFF));
      ticks_to_send.push_back(mk_tick(12'd500, 1'b0, SPEED_OFF));
      ticks_to_send.push_back(mk_tick(12'd1999, 1'b0, SPEED_OFF));
      ticks_to_send.push_back(mk_tick(12'd2000, 1'b0, SPEED_OFF));
      ticks_to_send.push_back(mk_tick(12'd3499, 1'b0, SPEED_OFF));
      ticks_to_send.push_back(mk_tick(12'd3500, 1'b0, SPEED_OFF));
      ticks_to_send.push_back(mk_tick(12'd4095, 1'b0, SPEED_OFF));
      ticks_to_send.push_back(mk_tick(12'd4095, 1'b1, SPEED_OFF));
      ticks_to_send.push_back(mk_tick(12'd0, 1'b1, SPEED_PULSE));
      ticks_to_send.push_back(mk_tick(12'd0, 1'b1, SPEED_SLOW));
      ticks_to_send.push_back(mk_tick(12'd0, 1'b1, SPEED_FAST));
      wait_drained();

      // thresholds out of order, zero and one-tick phase times, no pause
      write_settings(make_cfg(1000, 500, 4095, 0, TICK_STEP_MS, TICK_STEP_MS + 1, 0));
      ticks_to_send.push_back(mk_tick(12'd0, 1'b1, SPEED_PULSE));
      ticks_to_send.push_back(mk_tick(12'd0, 1'b1, SPEED_PULSE));
      ticks_to_send.push_back(mk_tick(12'd0, 1'b1, SPEED_PULSE));
      ticks_to_send.push_back(mk_tick(12'd0, 1'b1, SPEED_OFF));
      ticks_to_send.push_back(mk_tick(12'd0, 1'b1, SPEED_SLOW));
      ticks_to_send.push_back(mk_tick(12'd0, 1'b1, SPEED_SLOW));
      ticks_to_send.push_back(mk_tick(12'd0, 1'b1, SPEED_FAST));
      ticks_to_send.push_back(mk_tick(12'd0, 1'b1, SPEED_FAST));
      ticks_to_send.push_back(mk_tick(12'd0, 1'b1, SPEED_FAST));
      ticks_to_send.push_back(mk_tick(12'd999, 1'b0, SPEED_FAST));
      ticks_to_send.push_back(mk_tick(12'd1000, 1'b0, SPEED_FAST));
      ticks_to_send.push_back(mk_tick(12'd4094, 1'b0, SPEED_OFF));
      ticks_to_send.push_back(mk_tick(12'd4095, 1'b0, SPEED_OFF));
      wait_drained();

      write_settings(random_cfg(150, 1'b1));
      queue_random_ticks(230);
      wait_drained();

      // top of every range: knob almost always off, sweeps far too long to end
      write_settings(make_cfg(4095, 4095, 4095, 16383, 16383, 16383, 16383));
      queue_random_ticks(120);
      wait_drained();

      write_settings(make_cfg(THRESH_INT_RESET, THRESH_LOW_RESET, THRESH_HIGH_RESET,
                              SWEEP_INT_RESET, SWEEP_LOW_RESET, SWEEP_HIGH_RESET,
                              PAUSE_RESET));
      queue_random_ticks(230);
      wait_drained();

      write_settings(random_cfg(200, 1'b0));
      queue_random_ticks(250);
      wait_drained();

      // bottom of every range
      write_settings(make_cfg(0, 0, 0, 0, 0, 0, 0));
      queue_random_ticks(200);
      wait_drained();

      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
